@@ hw/rtl/linear_probe_hash_insert_macros.svh @@
`ifndef LINEAR_PROBE_HASH_INSERT_MACROS_SVH
`define LINEAR_PROBE_HASH_INSERT_MACROS_SVH

// same-cycle implication, needs clk and arst_n in scope
`define LPH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, needs clk and arst_n in scope
`define LPH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lph_pkg.sv @@
package lph_pkg;

	localparam int KEY_W = 31;
	localparam int PAY_W = 64;
	localparam int SLOT_W = 4;

	// key remainder unit: bits folded in per cycle
	localparam int MOD_BITS = 4;
	localparam int MOD_DIGITS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
	localparam int MOD_PAD_W = MOD_DIGITS * MOD_BITS;
	localparam int MOD_CNT_W = $clog2(MOD_DIGITS);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DUMP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FULL = 3'd1,
		ST_INVALID = 3'd2,
		ST_DUMP = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_PROBE,
		S_DUMP,
		S_EMIT
	} state_t;

endpackage

@@ hw/rtl/lph_if.sv @@
interface lph_req_if;
	logic valid;
	logic ready;
	logic op;
	logic [lph_pkg::KEY_W-1:0] key;
	logic [lph_pkg::PAY_W-1:0] payload;

	modport source (output valid, op, key, payload, input ready);
	modport sink (input valid, op, key, payload, output ready);
endinterface

interface lph_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [lph_pkg::SLOT_W-1:0] slot;
	logic [lph_pkg::KEY_W-1:0] key_out;
	logic [lph_pkg::PAY_W-1:0] payload_out;
	logic last;

	modport source (output valid, status, slot, key_out, payload_out, last, input ready);
	modport sink (input valid, status, slot, key_out, payload_out, last, output ready);
endinterface

@@ hw/rtl/lph_mem.sv @@
module lph_mem #(
	parameter int TABLE_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rd_en,
	input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
	output logic rd_occ,
	output logic [lph_pkg::KEY_W-1:0] rd_key,
	output logic [lph_pkg::PAY_W-1:0] rd_payload,
	input  logic wr_en,
	input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
	input  logic [lph_pkg::KEY_W-1:0] wr_key,
	input  logic [lph_pkg::PAY_W-1:0] wr_payload
);
	import lph_pkg::*;

	logic [KEY_W-1:0] key_mem [TABLE_SIZE];
	logic [PAY_W-1:0] pay_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] occ_q;
	logic rd_occ_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [PAY_W-1:0] rd_pay_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_payload;
		end
		if (rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_pay_q <= pay_mem[rd_addr];
		end
	end

	// occupancy flags stand in for the all-zero key reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			rd_occ_q <= 1'b0;
		end else begin
			if (wr_en) begin
				occ_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_occ_q <= occ_q[rd_addr];
			end
		end
	end

	assign rd_occ = rd_occ_q;
	assign rd_key = rd_key_q;
	assign rd_payload = rd_pay_q;

endmodule

@@ hw/rtl/lph_mod.sv @@
module lph_mod #(
	parameter int TABLE_SIZE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [lph_pkg::KEY_W-1:0] key,
	output logic done,
	output logic [$clog2(TABLE_SIZE)-1:0] rem
);
	import lph_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int R_W = IDX_W + 1;

	logic busy_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [MOD_PAD_W-1:0] sh_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] rem_nxt;
	logic last_digit;

	// msb-first remainder, one digit per cycle
	always_comb begin
		logic [R_W-1:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < MOD_BITS; i++) begin
			r = {r[IDX_W-1:0], sh_q[MOD_PAD_W-1-i]};
			if (r >= R_W'(TABLE_SIZE)) begin
				r = r - R_W'(TABLE_SIZE);
			end
		end
		rem_nxt = r[IDX_W-1:0];
	end

	assign last_digit = cnt_q == MOD_CNT_W'(MOD_DIGITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_digit) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= MOD_PAD_W'(key);
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << MOD_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign done = busy_q && last_digit;
	assign rem = rem_nxt;

endmodule

@@ hw/rtl/linear_probe_hash_insert.sv @@
// Open-addressing hash table with linear probing, TABLE_SIZE slots.
// req channel (sink): op, key, payload; accepted when valid and ready are high.
// rsp channel (source): status, slot, key_out, payload_out, last.
// One item is worked on at a time; ready is high only while the table is idle.
// Insert: key mod TABLE_SIZE is found by a remainder unit, 4 key bits per cycle,
// then the key memory is read one slot per cycle from that slot on.
// An insert of k probes (k from 1 to TABLE_SIZE) gives a single result; a zero
// key is not probed and is answered with an invalid status.
// Dump: every slot is read once, one per cycle while the receiver keeps up;
// it gives one result per occupied slot, last on the final one, or one empty
// status. The rate is set by the single read port of the slot memory.
// A registered output stage holds a result while rsp.ready is low; the
// dump scan then waits, so no result is lost, and a new item may be accepted
// while the last result of the previous one still waits.
// Reset (arst_n low) marks all slots empty at once and empties the output.
module linear_probe_hash_insert #(
	parameter int TABLE_SIZE = 16
) (
	input logic clk,
	input logic arst_n,
	lph_req_if.sink req,
	lph_rsp_if.source rsp
);
	import lph_pkg::*;
	`include "linear_probe_hash_insert_macros.svh"

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	state_t state_q, state_nxt;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] ptr_q;
	logic rd_vld_s1;
	logic last_s1;
	logic [IDX_W-1:0] idx_s1;

	logic pend_vld_q;
	logic [IDX_W-1:0] pend_slot_q;
	logic [KEY_W-1:0] pend_key_q;
	logic [PAY_W-1:0] pend_pay_q;

	status_t res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [KEY_W-1:0] res_key_q;
	logic [PAY_W-1:0] res_pay_q;

	logic out_vld_q;
	status_t out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [KEY_W-1:0] out_key_q;
	logic [PAY_W-1:0] out_pay_q;
	logic out_last_q;

	logic accept;
	logic out_free;
	logic issue;
	logic consume;
	logic term;
	logic fin;
	logic emit_pend;
	logic out_from_res;
	logic res_load;
	status_t res_status;
	logic [SLOT_W-1:0] res_slot;
	logic [KEY_W-1:0] res_key;
	logic [PAY_W-1:0] res_pay;
	logic mod_start;
	logic mod_done;
	logic [IDX_W-1:0] mod_rem;
	logic mem_we;
	logic rd_occ;
	logic [KEY_W-1:0] rd_key;
	logic [PAY_W-1:0] rd_pay;

	assign accept = req.valid && req.ready;
	assign out_free = !out_vld_q || rsp.ready;

	lph_mod #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mod_start),
		.key(req.key),
		.done(mod_done),
		.rem(mod_rem)
	);

	lph_mem #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(issue),
		.rd_addr(ptr_q),
		.rd_occ(rd_occ),
		.rd_key(rd_key),
		.rd_payload(rd_pay),
		.wr_en(mem_we),
		.wr_addr(idx_s1),
		.wr_key(key_q),
		.wr_payload(pay_q)
	);

	always_comb begin
		req.ready = 1'b0;
		mod_start = 1'b0;
		issue = 1'b0;
		consume = 1'b0;
		term = 1'b0;
		fin = 1'b0;
		emit_pend = 1'b0;
		out_from_res = 1'b0;
		mem_we = 1'b0;
		res_load = 1'b0;
		res_status = ST_INVALID;
		res_slot = '0;
		res_key = '0;
		res_pay = '0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				mod_start = accept && req.op == OP_INSERT && req.key != '0;
				res_load = accept && req.op == OP_INSERT && req.key == '0;
			end
			S_PROBE: begin
				term = rd_vld_s1 && (!rd_occ || last_s1);
				issue = cnt_q != CNT_W'(TABLE_SIZE) && !term;
				consume = rd_vld_s1;
				mem_we = rd_vld_s1 && !rd_occ;
				res_load = term;
				res_status = rd_occ ? ST_FULL : ST_INSERTED;
				res_slot = rd_occ ? '0 : SLOT_W'(idx_s1);
				res_key = key_q;
			end
			S_DUMP: begin
				// hold the previous hit until the next one shows whether it is last
				consume = rd_vld_s1 && (!rd_occ || !pend_vld_q || out_free);
				issue = cnt_q != CNT_W'(TABLE_SIZE) && (!rd_vld_s1 || consume);
				emit_pend = consume && rd_occ && pend_vld_q;
				fin = cnt_q == CNT_W'(TABLE_SIZE) && !rd_vld_s1;
				res_load = fin;
				res_status = pend_vld_q ? ST_DUMP : ST_EMPTY;
				res_slot = pend_vld_q ? SLOT_W'(pend_slot_q) : '0;
				res_key = pend_vld_q ? pend_key_q : '0;
				res_pay = pend_vld_q ? pend_pay_q : '0;
			end
			S_EMIT: begin
				out_from_res = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.op == OP_DUMP) begin
						state_nxt = S_DUMP;
					end else if (req.key == '0) begin
						state_nxt = S_EMIT;
					end else begin
						state_nxt = S_MOD;
					end
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_nxt = S_PROBE;
				end
			end
			S_PROBE: begin
				if (term) begin
					state_nxt = S_EMIT;
				end
			end
			S_DUMP: begin
				if (fin) begin
					state_nxt = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_IDLE && accept) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else if (state_q == S_MOD && mod_done) begin
				cnt_q <= '0;
				ptr_q <= mod_rem;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= (ptr_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : ptr_q + 1'b1;
			end
			if (issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (consume) begin
				rd_vld_s1 <= 1'b0;
			end
			if (fin) begin
				pend_vld_q <= 1'b0;
			end else if (state_q == S_DUMP && consume && rd_occ) begin
				pend_vld_q <= 1'b1;
			end
			if (out_from_res || emit_pend) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.key;
			pay_q <= req.payload;
		end
		if (issue) begin
			idx_s1 <= ptr_q;
			last_s1 <= cnt_q == CNT_W'(TABLE_SIZE - 1);
		end
		if (state_q == S_DUMP && consume && rd_occ) begin
			pend_slot_q <= idx_s1;
			pend_key_q <= rd_key;
			pend_pay_q <= rd_pay;
		end
		if (res_load) begin
			res_status_q <= res_status;
			res_slot_q <= res_slot;
			res_key_q <= res_key;
			res_pay_q <= res_pay;
		end
		if (out_from_res) begin
			out_status_q <= res_status_q;
			out_slot_q <= res_slot_q;
			out_key_q <= res_key_q;
			out_pay_q <= res_pay_q;
			out_last_q <= 1'b1;
		end else if (emit_pend) begin
			out_status_q <= ST_DUMP;
			out_slot_q <= SLOT_W'(pend_slot_q);
			out_key_q <= pend_key_q;
			out_pay_q <= pend_pay_q;
			out_last_q <= 1'b0;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.status = out_status_q;
	assign rsp.slot = out_slot_q;
	assign rsp.key_out = out_key_q;
	assign rsp.payload_out = out_pay_q;
	assign rsp.last = out_last_q;

	`LPH_ASSERT_NOW(a_idle_clean, state_q == S_IDLE, !rd_vld_s1 && !pend_vld_q, "stale scan state in idle")
	`LPH_ASSERT_NEXT(a_write_emit, mem_we, state_q == S_EMIT, "slot write not followed by result")
	`LPH_ASSERT_NOW(a_single_last, rsp.valid && rsp.status != ST_DUMP, rsp.last, "single result not last")
	`LPH_ASSERT_NEXT(a_dump_stall, state_q == S_DUMP && rd_vld_s1 && !consume, rd_vld_s1 && $stable(ptr_q) && $stable(idx_s1), "dump scan moved while stalled")

endmodule
